/* rtl/grouped_sorted_priority_queue_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the grouped sorted priority queue
// Shared forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef GROUPED_SORTED_PRIORITY_QUEUE_MACROS_SVH
`define GROUPED_SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define GSPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gspq check failed");

// Next-cycle implication, disabled while reset is low.
`define GSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gspq check failed");

`endif

/* rtl/gspq_pkg.sv */
// ----------------------------------------------------------------------------
// gspq_pkg
// Types and codes shared by the grouped sorted priority queue files.
// ----------------------------------------------------------------------------
`default_nettype none

package gspq_pkg;

    localparam logic [1:0] ACT_INSERT    = 2'd0;
    localparam logic [1:0] ACT_LIST_LOW  = 2'd1;
    localparam logic [1:0] ACT_REMOVE    = 2'd2;
    localparam logic [1:0] ACT_LIST_ALL  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [31:0] key;
        logic        [31:0] value;
    } t_entry;

endpackage

`default_nettype wire

/* rtl/gspq_if.sv */
// ----------------------------------------------------------------------------
// gspq_in_if / gspq_out_if
// Valid/ready channels for the queue commands and the queue results.
// ----------------------------------------------------------------------------
`default_nettype none

interface gspq_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  action;
    logic signed [31:0] item_key;
    logic        [31:0] item_value;

    modport source (output valid, output action, output item_key, output item_value,
                    input ready);
    modport sink   (input valid, input action, input item_key, input item_value,
                    output ready);
endinterface

interface gspq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_key;
    logic        [31:0] out_value;
    logic               is_last;
    logic        [5:0]  distinct_count;
    logic        [1:0]  status;

    modport source (output valid, output out_key, output out_value, output is_last,
                    output distinct_count, output status, input ready);
    modport sink   (input valid, input out_key, input out_value, input is_last,
                    input distinct_count, input status, output ready);
endinterface

`default_nettype wire

/* rtl/gspq_mem.sv */
// ----------------------------------------------------------------------------
// gspq_mem
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gspq_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire                  i_clk,
    input  wire                  i_we,
    input  wire [AW-1:0]         i_waddr,
    input  wire gspq_pkg::t_entry i_wdata,
    input  wire                  i_re,
    input  wire [AW-1:0]         i_raddr,
    output gspq_pkg::t_entry     o_rdata
);
    import gspq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/grouped_sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// grouped_sorted_priority_queue
// Bounded key/value queue kept in ascending key order in one entry memory.
// ----------------------------------------------------------------------------
// The entries sit in a circular buffer in a single memory with registered read
// data, so removing the lowest-key group only moves the head pointer. One
// command is handled at a time. An insert walks from the tail toward the head,
// moving each larger entry up by one slot at one entry per cycle. Listing and
// group removal read one entry per cycle, listing only while the output
// register can take a result, and listing delivers one result transaction per
// cycle; removal answers with a single transaction. Errors and inserts into
// an empty queue answer in the cycle after acceptance. A new command is taken
// once the previous run has been fully handed to the output register and that
// register is free or being read.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_sorted_priority_queue #(
    parameter int CAPACITY = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    gspq_in_if.sink     i_in,
    gspq_out_if.source  o_out
);
    import gspq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW:0]   CAP_S = (CW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_WEND = 3'd4;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW + 1)'(head) + {1'b0, off};
        if (s >= CAP_S) begin
            s = s - CAP_S;
        end
        return s[AW-1:0];
    endfunction

    logic [2:0]          r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_dist, n_dist;
    logic [AW-1:0]       r_i, n_i;
    logic [1:0]          r_act, n_act;
    t_entry              r_new, n_new;
    logic signed [31:0]  r_key0, n_key0;
    t_entry              r_held, n_held;

    logic                r_ovalid;
    t_entry              r_oent;
    logic                r_olast;
    logic [5:0]          r_odist;
    logic [1:0]          r_ostat;

    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    t_entry              mem_wdata, rd;

    logic                do_emit, e_last;
    t_entry              e_ent;
    logic [1:0]          e_stat;

    logic                ofree, in_ready, accept, belongs, emits, need;
    logic [CW-1:0]       i_ext, i_next;

    gspq_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    assign ofree    = !r_ovalid || o_out.ready;
    assign in_ready = (r_state == S_IDLE) && ofree;
    assign accept   = i_in.valid && in_ready;
    assign i_ext    = CW'(r_i);
    assign i_next   = i_ext + CW'(1);
    assign emits    = (r_act != ACT_REMOVE);
    assign belongs  = (r_act == ACT_LIST_ALL) || (r_i == '0) || (rd.key == r_key0);
    assign need     = emits && (r_i != '0);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_dist    = r_dist;
        n_i       = r_i;
        n_act     = r_act;
        n_new     = r_new;
        n_key0    = r_key0;
        n_held    = r_held;
        mem_we    = 1'b0;
        mem_waddr = r_head;
        mem_wdata = r_new;
        mem_re    = 1'b0;
        mem_raddr = r_head;
        do_emit   = 1'b0;
        e_ent     = '0;
        e_last    = 1'b1;
        e_stat    = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_act       = i_in.action;
                    n_new.key   = i_in.item_key;
                    n_new.value = i_in.item_value;
                    if (i_in.action == ACT_INSERT) begin
                        if (r_count == CAP_C) begin
                            do_emit = 1'b1;
                            e_stat  = ST_FULL;
                        end else if (r_count == '0) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_head;
                            mem_wdata = n_new;
                            n_count   = r_count + CW'(1);
                            n_dist    = r_dist + CW'(1);
                            do_emit   = 1'b1;
                        end else begin
                            n_i       = AW'(r_count - CW'(1));
                            mem_re    = 1'b1;
                            mem_raddr = f_phys(r_head, r_count - CW'(1));
                            n_state   = S_INS;
                        end
                    end else if (r_count == '0) begin
                        do_emit = 1'b1;
                        e_stat  = ST_EMPTY;
                    end else begin
                        n_i       = '0;
                        mem_re    = 1'b1;
                        mem_raddr = r_head;
                        n_state   = S_WALK;
                    end
                end
            end
            S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = f_phys(r_head, i_next);
                if (r_new.key < rd.key) begin
                    // Larger entry moves up one slot.
                    mem_wdata = rd;
                    if (r_i == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_i       = r_i - AW'(1);
                        mem_re    = 1'b1;
                        mem_raddr = f_phys(r_head, i_ext - CW'(1));
                    end
                end else begin
                    // The entry just below is the largest key not above the new one,
                    // so an equal key can only sit there.
                    mem_wdata = r_new;
                    n_count   = r_count + CW'(1);
                    n_dist    = r_dist + CW'(rd.key != r_new.key);
                    do_emit   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_FIN: begin
                mem_we    = 1'b1;
                mem_waddr = r_head;
                mem_wdata = r_new;
                n_count   = r_count + CW'(1);
                n_dist    = r_dist + CW'(1);
                do_emit   = 1'b1;
                n_state   = S_IDLE;
            end
            S_WALK: begin
                if (!belongs) begin
                    if (ofree) begin
                        do_emit = 1'b1;
                        if (emits) begin
                            e_ent = r_held;
                        end else begin
                            n_head  = f_phys(r_head, i_ext);
                            n_count = r_count - i_ext;
                            n_dist  = r_dist - CW'(r_dist != '0);
                        end
                        n_state = S_IDLE;
                    end
                end else if (!need || ofree) begin
                    if (need) begin
                        do_emit = 1'b1;
                        e_ent   = r_held;
                        e_last  = 1'b0;
                    end
                    n_held = rd;
                    if (r_i == '0) begin
                        n_key0 = rd.key;
                    end
                    if (i_next == r_count) begin
                        n_state = S_WEND;
                    end else begin
                        n_i       = r_i + AW'(1);
                        mem_re    = 1'b1;
                        mem_raddr = f_phys(r_head, i_next);
                    end
                end
            end
            S_WEND: begin
                if (ofree) begin
                    do_emit = 1'b1;
                    if (emits) begin
                        e_ent = r_held;
                    end else begin
                        n_head  = f_phys(r_head, r_count);
                        n_count = '0;
                        n_dist  = r_dist - CW'(r_dist != '0);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_dist   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_dist  <= n_dist;
            if (do_emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_act  <= n_act;
        r_new  <= n_new;
        r_key0 <= n_key0;
        r_held <= n_held;
        if (do_emit) begin
            r_oent  <= e_ent;
            r_olast <= e_last;
            r_odist <= 6'(n_dist);
            r_ostat <= e_stat;
        end
    end

    assign i_in.ready           = in_ready;
    assign o_out.valid          = r_ovalid;
    assign o_out.out_key        = r_oent.key;
    assign o_out.out_value      = r_oent.value;
    assign o_out.is_last        = r_olast;
    assign o_out.distinct_count = r_odist;
    assign o_out.status         = r_ostat;

endmodule

`default_nettype wire

/* rtl/gspq_checker.sv */
// ----------------------------------------------------------------------------
// gspq_checker
// Port-level checks of the result channel of the priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grouped_sorted_priority_queue_macros.svh"

module gspq_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire         i_ready,
    input  wire [31:0]  i_key,
    input  wire [31:0]  i_value,
    input  wire         i_last,
    input  wire [1:0]   i_status
);
    import gspq_pkg::*;

    // An error answer is always a run of one transaction.
    `GSPQ_ASSERT_NOW(a_err_last, i_clk, i_rst_n, i_valid && (i_status != ST_OK), i_last)

    // An error answer carries no entry.
    `GSPQ_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, i_valid && (i_status != ST_OK), (i_key == 32'd0) && (i_value == 32'd0))

    // A stalled result holds its payload.
    `GSPQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_key) && $stable(i_value) && $stable(i_last) && $stable(i_status))

endmodule

bind grouped_sorted_priority_queue gspq_checker u_gspq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_key    (o_out.out_key),
    .i_value  (o_out.out_value),
    .i_last   (o_out.is_last),
    .i_status (o_out.status)
);

`default_nettype wire

/* dv/grouped_sorted_priority_queue_tb.sv */
// ----------------------------------------------------------------------------
// Grouped sorted priority queue testbench
// Drives insert, list and remove commands through the valid/ready input
// channel and compares every result transaction against an internal sorted
// queue predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module grouped_sorted_priority_queue_tb;
    import gspq_pkg::*;

    localparam int CAP = 32;
    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        logic signed [31:0] key;
        logic        [31:0] value;
        logic               last;
        logic        [5:0]  distinct;
        logic        [1:0]  status;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    gspq_in_if  cmd_ch ();
    gspq_out_if res_ch ();

    grouped_sorted_priority_queue #(.CAPACITY(CAP)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch.sink),
        .o_out   (res_ch.source)
    );

    // Predictor state.
    t_entry  model_q[$];
    int      model_distinct;
    t_result pending_results[$];

    int  error_count;
    int  cycle_count;
    bit  idle_enable;
    bit  hold_off;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_result make_result(logic signed [31:0] k, logic [31:0] v,
                                            logic last, logic [1:0] st);
        t_result r;
        r.key      = k;
        r.value    = v;
        r.last     = last;
        r.distinct = model_distinct[5:0];
        r.status   = st;
        return r;
    endfunction

    function automatic void add_expected(t_result r);
        pending_results = {pending_results, r};
    endfunction

    // Applies one command to the predicted queue and queues its results.
    function automatic void predict_command(logic [1:0] act, logic signed [31:0] k,
                                            logic [31:0] v);
        int     pos;
        int     grp;
        bit     dup;
        t_entry e;
        pos = 0;
        dup = 0;
        if (act == ACT_INSERT) begin
            if (model_q.size() >= CAP) begin
                add_expected(make_result(0, 0, 1'b1, ST_FULL));
                return;
            end
            while (pos < model_q.size() && model_q[pos].key <= k) begin
                if (model_q[pos].key == k) dup = 1;
                pos++;
            end
            e.key   = k;
            e.value = v;
            model_q.insert(pos, e);
            if (!dup) model_distinct++;
            add_expected(make_result(0, 0, 1'b1, ST_OK));
            return;
        end
        if (model_q.size() == 0) begin
            add_expected(make_result(0, 0, 1'b1, ST_EMPTY));
            return;
        end
        grp = 1;
        while (grp < model_q.size() && model_q[grp].key == model_q[0].key) grp++;
        case (act)
            ACT_LIST_LOW: begin
                for (int i = 0; i < grp; i++)
                    add_expected(make_result(model_q[i].key,
                        model_q[i].value, i == grp - 1, ST_OK));
            end
            ACT_REMOVE: begin
                for (int i = 0; i < grp; i++) void'(model_q.pop_front());
                if (model_distinct > 0) model_distinct--;
                add_expected(make_result(0, 0, 1'b1, ST_OK));
            end
            default: begin
                for (int i = 0; i < model_q.size(); i++)
                    add_expected(make_result(model_q[i].key,
                        model_q[i].value, i == model_q.size() - 1, ST_OK));
            end
        endcase
    endfunction

    // Result ready with random stalls and an optional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_off) begin
            res_ch.ready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            res_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            res_ch.ready <= 1'b1;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no expectation");
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (res_ch.out_key !== exp_r.key) begin
                    $error("out_key exp %0d got %0d", exp_r.key, res_ch.out_key);
                    error_count++;
                end
                if (res_ch.out_value !== exp_r.value) begin
                    $error("out_value exp %h got %h", exp_r.value, res_ch.out_value);
                    error_count++;
                end
                if (res_ch.is_last !== exp_r.last) begin
                    $error("is_last exp %b got %b", exp_r.last, res_ch.is_last);
                    error_count++;
                end
                if (res_ch.distinct_count !== exp_r.distinct) begin
                    $error("distinct_count exp %0d got %0d", exp_r.distinct,
                           res_ch.distinct_count);
                    error_count++;
                end
                if (res_ch.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, res_ch.status);
                    error_count++;
                end
            end
        end
    end

    // Offers one command and waits until it is accepted. Valid stays high
    // afterwards so that commands can follow back to back; an idle gap or
    // the drain task drops it.
    task automatic send_command(logic [1:0] act, logic signed [31:0] k, logic [31:0] v);
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.action     <= act;
        cmd_ch.item_key   <= k;
        cmd_ch.item_value <= v;
        do @(posedge i_clk); while (!cmd_ch.ready);
        predict_command(act, k, v);
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_queue();
        send_command(ACT_LIST_LOW, 0, 0);
        send_command(ACT_REMOVE, 0, 0);
        send_command(ACT_LIST_ALL, 0, 0);
    endtask

    task automatic test_directed_ordering();
        send_command(ACT_INSERT, 32'sh7FFFFFFF, 32'hFFFFFFFF);
        send_command(ACT_INSERT, 32'sh80000000, 32'h00000000);
        send_command(ACT_INSERT, 32'sh80000000, 32'hAAAAAAAA);
        send_command(ACT_INSERT, 0, 32'h55555555);
        send_command(ACT_INSERT, -1, 32'h12345678);
        send_command(ACT_INSERT, 32'sh7FFFFFFF, 32'h1);
        send_command(ACT_LIST_ALL, 0, 0);
        send_command(ACT_LIST_LOW, 0, 0);
        send_command(ACT_REMOVE, 0, 0);
        send_command(ACT_LIST_LOW, 0, 0);
        send_command(ACT_REMOVE, 0, 0);
        send_command(ACT_REMOVE, 0, 0);
        send_command(ACT_REMOVE, 0, 0);
        send_command(ACT_LIST_ALL, 0, 0);
        send_command(ACT_REMOVE, 0, 0);
        send_command(ACT_REMOVE, 0, 0);
        drain_results();
    endtask

    // Fills the queue with equal keys so the full case and a 32-entry group
    // are both seen, then empties it.
    task automatic test_full_queue();
        for (int i = 0; i < CAP; i++) send_command(ACT_INSERT, 5, i);
        send_command(ACT_INSERT, -5, 32'hDEADBEEF);
        send_command(ACT_LIST_LOW, 0, 0);
        send_command(ACT_REMOVE, 0, 0);
        drain_results();
    endtask

    task automatic test_random_traffic(int count, int key_span);
        int   r;
        logic [1:0] act;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55)      act = ACT_INSERT;
            else if (r < 70) act = ACT_LIST_LOW;
            else if (r < 88) act = ACT_REMOVE;
            else             act = ACT_LIST_ALL;
            // Narrow key spans make groups; the wide span flips every key bit.
            if (key_span == 0)
                send_command(act, $urandom, $urandom);
            else
                send_command(act, $signed($urandom_range(0, key_span)) - key_span / 2,
                             $urandom);
        end
    endtask

    // Holds result ready low while commands keep coming, so the block stalls.
    task automatic test_output_backpressure();
        hold_off = 1'b1;
        fork
            begin
                for (int i = 0; i < 6; i++) send_command(ACT_INSERT, $urandom, $urandom);
            end
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        drain_results();
    endtask

    initial begin
        error_count  = 0;
        cycle_count  = 0;
        idle_enable  = 1'b0;
        hold_off     = 1'b0;
        i_rst_n      = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.action     = ACT_INSERT;
        cmd_ch.item_key   = '0;
        cmd_ch.item_value = '0;
        model_distinct = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_directed_ordering();
        idle_enable = 1'b1;
        test_full_queue();
        test_output_backpressure();
        test_random_traffic(60, 8);
        test_random_traffic(60, 0);
        idle_enable = 1'b0;
        test_random_traffic(50, 20);

        drain_results();
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/gspq_pkg.sv
rtl/gspq_if.sv
rtl/gspq_mem.sv
rtl/grouped_sorted_priority_queue.sv
rtl/gspq_checker.sv
dv/grouped_sorted_priority_queue_tb.sv
